// ===== sv/pauli_string_basis_apply_unit_assert.svh =====
// Assertion macros for the Pauli string basis apply unit.
// No dependencies; included by the checker file.
`ifndef PAULI_STRING_BASIS_APPLY_UNIT_ASSERT_SVH
`define PAULI_STRING_BASIS_APPLY_UNIT_ASSERT_SVH

// Same-cycle implication, masked during reset.
`define PSBA_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("psba assertion failed");

// Next-cycle implication, active during reset too.
`define PSBA_ASSERT_NXT(lbl, clk, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("psba assertion failed");

`endif

// ===== sv/psba_pkg.sv =====
// Types and constants shared by the Pauli string basis apply unit.
// No dependencies.
package psba_pkg;

    localparam int MAX_SITES = 16;
    localparam int MAX_OPS   = 4;
    localparam int STATE_W   = 16;
    localparam int OPS_W     = 8;
    localparam int CNT_W     = 3;
    localparam int SITE_W    = 4;
    localparam int RING_W    = 5;
    localparam int OP_W      = 2;
    localparam int PHASE_W   = 2;

    localparam logic [RING_W-1:0] RING_RESET = RING_W'(MAX_SITES);

    typedef enum logic [OP_W-1:0] {
        OP_I = 2'd0,
        OP_X = 2'd1,
        OP_Y = 2'd2,
        OP_Z = 2'd3
    } t_pauli;

    localparam logic [PHASE_W-1:0] PH_ONE   = 2'd0;
    localparam logic [PHASE_W-1:0] PH_I     = 2'd1;
    localparam logic [PHASE_W-1:0] PH_NEG   = 2'd2;
    localparam logic [PHASE_W-1:0] PH_NEG_I = 2'd3;

    typedef struct packed {
        logic [STATE_W-1:0] basis_state;
        logic [OPS_W-1:0]   pauli_ops;
        logic [CNT_W-1:0]   op_count;
        logic [SITE_W-1:0]  start_site;
    } t_item;

    typedef struct packed {
        logic [STATE_W-1:0]             state;
        t_pauli [MAX_OPS-1:0]           ops;
        logic [MAX_OPS-1:0][SITE_W-1:0] site;
        logic [MAX_OPS-1:0]             op_en;
        logic                           bad;
    } t_dec;

    typedef struct packed {
        logic [STATE_W-1:0] state;
        logic [STATE_W-1:0] flip;
        logic [PHASE_W-1:0] phase;
        logic               bad;
    } t_term;

    typedef struct packed {
        logic [STATE_W-1:0] new_state;
        logic [PHASE_W-1:0] phase;
        logic               bad_request;
    } t_res;

endpackage

// ===== sv/psba_item_if.sv =====
// Input channel: basis state and Pauli string, valid/ready handshake.
// Depends on psba_pkg.
interface psba_item_if;
    logic                          valid;
    logic                          ready;
    logic [psba_pkg::STATE_W-1:0]  basis_state;
    logic [psba_pkg::OPS_W-1:0]    pauli_ops;
    logic [psba_pkg::CNT_W-1:0]    op_count;
    logic [psba_pkg::SITE_W-1:0]   start_site;

    modport source (output valid, basis_state, pauli_ops, op_count, start_site,
                    input ready);
    modport sink   (input valid, basis_state, pauli_ops, op_count, start_site,
                    output ready);
endinterface

// ===== sv/psba_result_if.sv =====
// Output channel: new state, phase and bad-request flag, valid/ready handshake.
// Depends on psba_pkg.
interface psba_result_if;
    logic                          valid;
    logic                          ready;
    logic [psba_pkg::STATE_W-1:0]  new_state;
    logic [psba_pkg::PHASE_W-1:0]  phase;
    logic                          bad_request;

    modport source (output valid, new_state, phase, bad_request, input ready);
    modport sink   (input valid, new_state, phase, bad_request, output ready);
endinterface

// ===== sv/psba_decode.sv =====
// Stage 1: saturates ring size and count, flags bad requests, resolves sites.
// Depends on psba_pkg.
module psba_decode (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [psba_pkg::RING_W-1:0]   i_ring_size,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  psba_pkg::t_item               i_item,
    output logic                          o_valid,
    input  logic                          i_ready,
    output psba_pkg::t_dec                o_dec
);
    import psba_pkg::*;

    logic                r_valid;
    t_dec                r_dec;
    t_dec                n_dec;
    logic [RING_W-1:0]   ring_eff;
    logic [CNT_W-1:0]    cnt_eff;
    logic [RING_W-1:0]   site_sum [MAX_OPS];

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_dec   = r_dec;

    always_comb begin
        ring_eff = (i_ring_size > RING_W'(MAX_SITES)) ? RING_W'(MAX_SITES) : i_ring_size;
        cnt_eff  = (i_item.op_count > CNT_W'(MAX_OPS)) ? CNT_W'(MAX_OPS) : i_item.op_count;
        n_dec.state = i_item.basis_state;
        n_dec.bad   = ({1'b0, i_item.start_site} >= ring_eff)
                   || (RING_W'(cnt_eff) > ring_eff);
        for (int j = 0; j < MAX_OPS; j++) begin
            // start < n and j < n when the request is good: one wrap at most
            site_sum[j] = {1'b0, i_item.start_site} + RING_W'(j);
            if (site_sum[j] >= ring_eff) begin
                site_sum[j] = site_sum[j] - ring_eff;
            end
            n_dec.site[j]  = site_sum[j][SITE_W-1:0];
            n_dec.ops[j]   = t_pauli'(i_item.pauli_ops[OP_W*j +: OP_W]);
            n_dec.op_en[j] = !n_dec.bad && (CNT_W'(j) < cnt_eff);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_dec <= n_dec;
        end
    end

endmodule

// ===== sv/psba_term.sv =====
// Stage 2: per-operator flip mask and phase accumulation.
// Depends on psba_pkg.
module psba_term (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  psba_pkg::t_dec  i_dec,
    output logic            o_valid,
    input  logic            i_ready,
    output psba_pkg::t_term o_term
);
    import psba_pkg::*;

    logic   r_valid;
    t_term  r_term;
    t_term  n_term;
    logic   site_bit;

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_term  = r_term;

    always_comb begin
        n_term.state = i_dec.state;
        n_term.bad   = i_dec.bad;
        n_term.flip  = '0;
        n_term.phase = PH_ONE;
        site_bit     = 1'b0;
        // sites are distinct for a good request, so every operator sees the input bit
        for (int j = 0; j < MAX_OPS; j++) begin
            site_bit = i_dec.state[i_dec.site[j]];
            if (i_dec.op_en[j]) begin
                if (i_dec.ops[j] inside {OP_X, OP_Y}) begin
                    n_term.flip = n_term.flip | (STATE_W'(1) << i_dec.site[j]);
                end
                case (i_dec.ops[j])
                    OP_Y: begin
                        n_term.phase = n_term.phase + (site_bit ? PH_NEG_I : PH_I);
                    end
                    OP_Z: begin
                        if (site_bit) begin
                            n_term.phase = n_term.phase + PH_NEG;
                        end
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_term <= n_term;
        end
    end

endmodule

// ===== sv/psba_out.sv =====
// Stage 3: applies the flip mask and holds the result for the output channel.
// Depends on psba_pkg.
module psba_out (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  psba_pkg::t_term i_term,
    output logic            o_valid,
    input  logic            i_ready,
    output psba_pkg::t_res  o_res
);
    import psba_pkg::*;

    logic  r_valid;
    t_res  r_res;
    t_res  n_res;

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_res   = r_res;

    always_comb begin
        n_res.new_state   = i_term.state ^ i_term.flip;
        n_res.phase       = i_term.phase;
        n_res.bad_request = i_term.bad;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_res <= n_res;
        end
    end

endmodule

// ===== sv/pauli_string_basis_apply_unit.sv =====
// Pauli string basis apply unit: top level, three register stages.
// Items move through the decode, term and out stage registers in order to the output.
// Throughput: one item per cycle; each stage holds its item while the next is full.
// Reset (synchronous, active low): all stage valids cleared, ring size set to 16.
// Depends on psba_pkg, psba_item_if, psba_result_if, psba_decode, psba_term, psba_out.
module pauli_string_basis_apply_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_wr_en,
    input  logic [psba_pkg::RING_W-1:0]   i_cfg_wr_data,
    psba_item_if.sink                     i_item,
    psba_result_if.source                 o_result
);
    import psba_pkg::*;

    logic [RING_W-1:0] r_ring_size;
    t_item             item;
    t_dec              dec;
    t_term             term;
    t_res              res;
    logic              dec_valid;
    logic              dec_ready;
    logic              term_valid;
    logic              term_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ring_size <= RING_RESET;
        end else if (i_cfg_wr_en) begin
            r_ring_size <= i_cfg_wr_data;
        end
    end

    assign item.basis_state = i_item.basis_state;
    assign item.pauli_ops   = i_item.pauli_ops;
    assign item.op_count    = i_item.op_count;
    assign item.start_site  = i_item.start_site;

    psba_decode u_decode (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ring_size (r_ring_size),
        .i_valid     (i_item.valid),
        .o_ready     (i_item.ready),
        .i_item      (item),
        .o_valid     (dec_valid),
        .i_ready     (dec_ready),
        .o_dec       (dec)
    );

    psba_term u_term (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (dec_valid),
        .o_ready (dec_ready),
        .i_dec   (dec),
        .o_valid (term_valid),
        .i_ready (term_ready),
        .o_term  (term)
    );

    psba_out u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (term_valid),
        .o_ready (term_ready),
        .i_term  (term),
        .o_valid (o_result.valid),
        .i_ready (o_result.ready),
        .o_res   (res)
    );

    assign o_result.new_state   = res.new_state;
    assign o_result.phase       = res.phase;
    assign o_result.bad_request = res.bad_request;

endmodule

// ===== sv/psba_checker.sv =====
// Port-level checks for the Pauli string basis apply unit, bound to the top level.
// Depends on psba_pkg and pauli_string_basis_apply_unit_assert.svh.
`include "pauli_string_basis_apply_unit_assert.svh"

module psba_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_in_ready,
    input logic                          i_out_valid,
    input logic                          i_out_ready,
    input logic [psba_pkg::STATE_W-1:0]  i_new_state,
    input logic [psba_pkg::PHASE_W-1:0]  i_phase,
    input logic                          i_bad_request
);
    import psba_pkg::*;

    `PSBA_ASSERT_NXT(a_reset_empties, i_clk, !i_rst_n, !i_out_valid)
    `PSBA_ASSERT_NXT(a_stall_holds, i_clk, i_rst_n && i_out_valid && !i_out_ready, !i_rst_n || (i_out_valid && $stable(i_new_state) && $stable(i_phase) && $stable(i_bad_request)))
    `PSBA_ASSERT_IMP(a_empty_accepts, i_clk, i_rst_n, !i_out_valid, i_in_ready)
    `PSBA_ASSERT_IMP(a_bad_unit_phase, i_clk, i_rst_n, i_out_valid && i_bad_request, i_phase == PH_ONE)

endmodule

bind pauli_string_basis_apply_unit psba_checker u_psba_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_ready    (i_item.ready),
    .i_out_valid   (o_result.valid),
    .i_out_ready   (o_result.ready),
    .i_new_state   (o_result.new_state),
    .i_phase       (o_result.phase),
    .i_bad_request (o_result.bad_request)
);

// ===== test/tb_pauli_string_basis_apply_unit.sv =====
// Testbench for pauli_string_basis_apply_unit: directed and random Pauli strings over several
// ring sizes, random idling on both channels, self-checking against an in-bench predictor.
// Depends on psba_pkg, psba_item_if, psba_result_if and the unit itself.
module tb_pauli_string_basis_apply_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import psba_pkg::*;

    localparam int HOLD_CYCLES = 300;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_cfg_wr_en;
    logic [RING_W-1:0]   i_cfg_wr_data;

    psba_item_if   item_ch ();
    psba_result_if result_ch ();

    pauli_string_basis_apply_unit u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_item        (item_ch),
        .o_result      (result_ch)
    );

    logic [RING_W-1:0] ring_cfg;
    t_res              expected_results[$];
    int                error_count;
    bit                tx_gaps_on;
    bit                rx_gaps_on;
    bit                rx_hold_req;
    int                rx_stall_left;

    always begin
        i_clk = 1'b1;
        #2;
        i_clk = 1'b0;
        #2;
    end

    initial begin
        #4_000_000;
        $display("tb_pauli_string_basis_apply_unit failed");
        $finish;
    end

    function automatic t_res apply_pauli_string(t_item it, logic [RING_W-1:0] ring);
        int     n_sites;
        int     n_ops;
        int     site;
        t_pauli op;
        logic   bit_val;
        t_res   res;
        n_sites = (ring > MAX_SITES) ? MAX_SITES : int'(ring);
        n_ops   = (it.op_count > MAX_OPS) ? MAX_OPS : int'(it.op_count);
        res.new_state   = it.basis_state;
        res.phase       = PH_ONE;
        res.bad_request = (int'(it.start_site) >= n_sites) || (n_ops > n_sites);
        if (!res.bad_request) begin
            for (int j = 0; j < n_ops; j++) begin
                site    = (int'(it.start_site) + j) % n_sites;
                op      = t_pauli'(it.pauli_ops[2*j +: OP_W]);
                bit_val = it.basis_state[site];
                case (op)
                    OP_X: begin
                        res.new_state[site] = ~res.new_state[site];
                    end
                    OP_Y: begin
                        res.new_state[site] = ~res.new_state[site];
                        res.phase = res.phase + (bit_val ? PH_NEG_I : PH_I);
                    end
                    OP_Z: begin
                        if (bit_val) res.phase = res.phase + PH_NEG;
                    end
                    default: ;
                endcase
            end
        end
        return res;
    endfunction

    function automatic logic [OPS_W-1:0] pack_ops(t_pauli o0, t_pauli o1, t_pauli o2,
                                                  t_pauli o3);
        return {o3, o2, o1, o0};
    endfunction

    function automatic t_item mk_item(logic [STATE_W-1:0] st, logic [OPS_W-1:0] ops,
                                      logic [CNT_W-1:0] cnt, logic [SITE_W-1:0] start);
        t_item it;
        it.basis_state = st;
        it.pauli_ops   = ops;
        it.op_count    = cnt;
        it.start_site  = start;
        return it;
    endfunction

    // Mostly strings that fit the ring; the rest covers every field value
    function automatic t_item random_item();
        int    n_sites;
        int    sel;
        t_item it;
        n_sites = (ring_cfg > MAX_SITES) ? MAX_SITES : int'(ring_cfg);
        it.pauli_ops = OPS_W'($urandom);
        sel = $urandom_range(0, 99);
        it.basis_state = (sel < 5) ? '0 : (sel < 10) ? '1 : STATE_W'($urandom);
        if (n_sites > 0 && $urandom_range(0, 99) < 85) begin
            it.op_count   = CNT_W'($urandom_range(0, (n_sites < MAX_OPS) ? n_sites : MAX_OPS));
            it.start_site = SITE_W'($urandom_range(0, n_sites - 1));
        end else begin
            it.op_count   = CNT_W'($urandom);
            it.start_site = SITE_W'($urandom);
        end
        return it;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(25, 70);
    endfunction

    task automatic send_item(t_item it);
        int gap;
        item_ch.valid       <= 1'b1;
        item_ch.basis_state <= it.basis_state;
        item_ch.pauli_ops   <= it.pauli_ops;
        item_ch.op_count    <= it.op_count;
        item_ch.start_site  <= it.start_site;
        do @(posedge i_clk); while (!item_ch.ready);
        expected_results.insert(expected_results.size(), apply_pauli_string(it, ring_cfg));
        gap = tx_gaps_on ? pick_gap() : 0;
        if (gap > 0) begin
            item_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic wait_drained();
        item_ch.valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_ring_size(logic [RING_W-1:0] value);
        wait_drained();
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= value;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        ring_cfg = value;
    endtask

    task automatic test_directed_reset_ring();
        send_item(mk_item(16'h0000, pack_ops(OP_I, OP_I, OP_I, OP_I), 3'd0, 4'd0));
        send_item(mk_item(16'hFFFF, pack_ops(OP_Z, OP_Z, OP_Z, OP_Z), 3'd4, 4'd0));
        send_item(mk_item(16'h0000, pack_ops(OP_X, OP_X, OP_X, OP_X), 3'd4, 4'd14));
        send_item(mk_item(16'h0000, pack_ops(OP_Y, OP_Y, OP_Y, OP_Y), 3'd4, 4'd12));
        send_item(mk_item(16'hFFFF, pack_ops(OP_Y, OP_Y, OP_Y, OP_Y), 3'd4, 4'd15));
        send_item(mk_item(16'h0001, pack_ops(OP_Y, OP_I, OP_I, OP_I), 3'd1, 4'd0));
        send_item(mk_item(16'h0000, pack_ops(OP_Y, OP_I, OP_I, OP_I), 3'd1, 4'd0));
        send_item(mk_item(16'h0000, pack_ops(OP_Z, OP_I, OP_I, OP_I), 3'd1, 4'd0));
        send_item(mk_item(16'h0001, pack_ops(OP_Z, OP_I, OP_I, OP_I), 3'd1, 4'd0));
        send_item(mk_item(16'h8000, pack_ops(OP_X, OP_I, OP_I, OP_I), 3'd1, 4'd15));
        send_item(mk_item(16'h00A0, pack_ops(OP_I, OP_X, OP_Y, OP_Z), 3'd4, 4'd6));
        send_item(mk_item(16'h5A5A, pack_ops(OP_Z, OP_Y, OP_X, OP_I), 3'd7, 4'd3));
        send_item(mk_item(16'hA5A5, pack_ops(OP_Y, OP_Z, OP_Y, OP_X), 3'd5, 4'd9));
        send_item(mk_item(16'h1234, pack_ops(OP_X, OP_Y, OP_Z, OP_Y), 3'd6, 4'd15));
        send_item(mk_item(16'hC003, pack_ops(OP_X, OP_Z, OP_Y, OP_Y), 3'd2, 4'd15));
        send_item(mk_item(16'hFFFF, pack_ops(OP_X, OP_X, OP_X, OP_X), 3'd3, 4'd1));
        send_item(mk_item(16'h7FFE, pack_ops(OP_Z, OP_Z, OP_Y, OP_X), 3'd4, 4'd13));
    endtask

    task automatic test_ring_extremes();
        logic [RING_W-1:0] sizes [6];
        sizes = '{5'd0, 5'd1, 5'd31, 5'd17, 5'd2, 5'd3};
        foreach (sizes[k]) begin
            write_ring_size(sizes[k]);
            send_item(mk_item(16'hFFFF, pack_ops(OP_X, OP_Y, OP_Z, OP_Y), 3'd1, 4'd0));
            send_item(mk_item(16'h0003, pack_ops(OP_Y, OP_Y, OP_Y, OP_Y), 3'd2, 4'd0));
            send_item(mk_item(16'hAAAA, pack_ops(OP_X, OP_Z, OP_X, OP_Z), 3'd4, 4'd1));
            send_item(mk_item(16'h5555, pack_ops(OP_Z, OP_X, OP_Y, OP_I), 3'd3, 4'd15));
            repeat (6) send_item(random_item());
        end
    endtask

    task automatic test_random_traffic();
        logic [RING_W-1:0] sizes [7];
        sizes = '{5'd16, 5'd2, 5'd3, 5'd7, 5'd11, 5'd4, 5'd16};
        sizes[5] = RING_W'($urandom_range(2, 16));
        foreach (sizes[k]) begin
            write_ring_size(sizes[k]);
            tx_gaps_on = (k != 3);
            rx_gaps_on = (k != 3);
            repeat (200) send_item(random_item());
        end
        tx_gaps_on = 1'b1;
        rx_gaps_on = 1'b1;
    endtask

    // Receiver stalls for a long stretch while the sender keeps offering
    task automatic test_backpressure();
        write_ring_size(5'd16);
        tx_gaps_on  = 1'b0;
        rx_hold_req = 1'b1;
        repeat (60) send_item(random_item());
        tx_gaps_on = 1'b1;
        wait_drained();
        repeat (20) send_item(random_item());
    endtask

    always @(posedge i_clk) begin
        if (rx_stall_left > 0) begin
            rx_stall_left  <= rx_stall_left - 1;
            result_ch.ready <= 1'b0;
        end else if (rx_hold_req) begin
            rx_hold_req     = 1'b0;
            rx_stall_left  <= HOLD_CYCLES;
            result_ch.ready <= 1'b0;
        end else if (rx_gaps_on && $urandom_range(0, 99) < 20) begin
            rx_stall_left  <= pick_gap();
            result_ch.ready <= 1'b0;
        end else begin
            result_ch.ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        t_res exp_res;
        if (i_rst_n && result_ch.valid && result_ch.ready) begin
            if (expected_results.size() == 0) begin
                $display("%0t unexpected transfer: new_state %h phase %0d bad_request %0d",
                         $time, result_ch.new_state, result_ch.phase, result_ch.bad_request);
                error_count++;
            end else begin
                exp_res = expected_results.pop_front();
                if (result_ch.new_state !== exp_res.new_state) begin
                    $display("%0t new_state mismatch: expected %h actual %h",
                             $time, exp_res.new_state, result_ch.new_state);
                    error_count++;
                end
                if (result_ch.phase !== exp_res.phase) begin
                    $display("%0t phase mismatch: expected %0d actual %0d",
                             $time, exp_res.phase, result_ch.phase);
                    error_count++;
                end
                if (result_ch.bad_request !== exp_res.bad_request) begin
                    $display("%0t bad_request mismatch: expected %0d actual %0d",
                             $time, exp_res.bad_request, result_ch.bad_request);
                    error_count++;
                end
            end
        end
    end

    initial begin
        int wait_cycles;
        i_rst_n               = 1'b0;
        i_cfg_wr_en           = 1'b0;
        i_cfg_wr_data         = '0;
        item_ch.valid         = 1'b0;
        item_ch.basis_state   = '0;
        item_ch.pauli_ops     = '0;
        item_ch.op_count      = '0;
        item_ch.start_site    = '0;
        result_ch.ready       = 1'b0;
        ring_cfg              = RING_RESET;
        error_count           = 0;
        tx_gaps_on            = 1'b1;
        rx_gaps_on            = 1'b1;
        rx_hold_req           = 1'b0;
        rx_stall_left         = 0;
        wait_cycles           = 0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_directed_reset_ring();
        test_ring_extremes();
        test_random_traffic();
        test_backpressure();

        item_ch.valid <= 1'b0;
        while (expected_results.size() != 0 && wait_cycles < 20000) begin
            @(posedge i_clk);
            wait_cycles++;
        end
        repeat (8) @(posedge i_clk);
        if (expected_results.size() != 0) begin
            $display("%0t %0d expected results never arrived", $time, expected_results.size());
            error_count++;
        end
        if (error_count == 0) begin
            $display("tb_pauli_string_basis_apply_unit passed");
        end else begin
            $display("tb_pauli_string_basis_apply_unit failed");
        end
        $finish;
    end
endmodule
